// ===== rtl/tod_pkg.sv =====
// Shared types and constants for the time-of-day arithmetic unit.
// Depends on nothing; used by tod_amod, tod_split and the top level.
package tod_pkg;

    localparam int C_DAY       = 86400;
    localparam int C_HOUR      = 3600;
    localparam int C_MIN       = 60;
    localparam int C_MAX_HOUR  = 23;
    localparam int C_MAX_MS    = 59;
    localparam int C_DAY_SHIFT = 7;
    localparam int C_MOD_B     = C_DAY / (1 << C_DAY_SHIFT);
    localparam int C_FOLD      = 4096 % C_MOD_B;
    localparam int C_MIN_SHIFT = 18;
    localparam int C_MIN_RECIP = ((1 << C_MIN_SHIFT) + C_MIN - 1) / C_MIN;

    localparam logic [2:0] OP_VALIDATE = 3'd0;
    localparam logic [2:0] OP_TO_SECS  = 3'd1;
    localparam logic [2:0] OP_TO_TIME  = 3'd2;
    localparam logic [2:0] OP_COMPARE  = 3'd3;
    localparam logic [2:0] OP_ADD      = 3'd4;
    localparam logic [2:0] OP_SUB      = 3'd5;
    localparam logic [2:0] OP_DURATION = 3'd6;

    typedef logic [2:0]  t_op;
    typedef logic [16:0] t_secs;

    typedef struct packed {
        logic  is_valid;
        logic  is_equal;
        logic  is_less;
        logic  is_greater;
        t_secs seconds;
    } t_tag;

endpackage

// ===== rtl/tod_amod.sv =====
// Amount modulo 86400: fold the upper bits modulo 675, keep the low 7 bits.
// Two register stages. Depends on tod_pkg.
module tod_amod import tod_pkg::*; (
    input  logic        i_clk,
    input  logic [30:0] i_amount,
    output t_secs       o_rem
);

    logic [23:0] w_x;
    logic [17:0] w_f1;
    logic [12:0] w_f2;
    logic [12:0] n_fold;
    logic [12:0] r_fold;
    logic [6:0]  r_low;
    logic [12:0] n_sub;
    logic [9:0]  n_rem;
    t_secs       r_rem;

    assign w_x  = i_amount[30:7];
    assign w_f1 = 18'(w_x[23:12]) * 18'(C_FOLD) + 18'(w_x[11:0]);
    assign w_f2 = 13'(w_f1[17:12]) * 13'(C_FOLD) + 13'(w_f1[11:0]);

    always_comb begin
        if (w_f2[12]) begin
            n_fold = 13'(w_f2[11:0]) + 13'(C_FOLD);
        end else begin
            n_fold = 13'(w_f2[11:0]);
        end
    end

    always_comb begin
        n_sub = '0;
        for (int k = 1; k <= 6; k++) begin
            if (r_fold >= 13'(k * C_MOD_B)) begin
                n_sub = 13'(k * C_MOD_B);
            end
        end
        n_rem = 10'(r_fold - n_sub);
    end

    always_ff @(posedge i_clk) begin
        r_fold <= n_fold;
        r_low  <= i_amount[6:0];
        r_rem  <= {n_rem, r_low};
    end

    assign o_rem = r_rem;

endmodule

// ===== rtl/tod_split.sv =====
// Seconds since midnight (below 86400) to hour, minute and second.
// Three register stages; carries a result tag alongside. Depends on tod_pkg.
module tod_split import tod_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_secs      i_secs,
    input  t_tag       i_tag,
    output logic       o_vld,
    output logic [4:0] o_hour,
    output logic [5:0] o_minute,
    output logic [5:0] o_second,
    output t_tag       o_tag
);

    logic        r_a_vld;
    t_secs       r_a_secs;
    t_tag        r_a_tag;
    logic [4:0]  n_hour;
    logic [11:0] n_rem;
    logic        r_b_vld;
    logic [4:0]  r_b_hour;
    logic [11:0] r_b_rem;
    t_tag        r_b_tag;
    logic [24:0] w_prod;
    logic [5:0]  n_minute;
    logic [5:0]  n_second;
    logic        r_c_vld;
    logic [4:0]  r_c_hour;
    logic [5:0]  r_c_minute;
    logic [5:0]  r_c_second;
    t_tag        r_c_tag;

    always_comb begin
        n_hour = '0;
        for (int k = 1; k <= C_MAX_HOUR; k++) begin
            if (r_a_secs >= 17'(k * C_HOUR)) begin
                n_hour = 5'(k);
            end
        end
        n_rem = 12'(r_a_secs - 17'(n_hour) * 17'(C_HOUR));
    end

    assign w_prod   = 25'(r_b_rem) * 25'(C_MIN_RECIP);
    assign n_minute = w_prod[C_MIN_SHIFT +: 6];
    assign n_second = 6'(r_b_rem - 12'(n_minute) * 12'(C_MIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_secs   <= i_secs;
        r_a_tag    <= i_tag;
        r_b_hour   <= n_hour;
        r_b_rem    <= n_rem;
        r_b_tag    <= r_a_tag;
        r_c_hour   <= r_b_hour;
        r_c_minute <= n_minute;
        r_c_second <= n_second;
        r_c_tag    <= r_b_tag;
    end

    assign o_vld    = r_c_vld;
    assign o_hour   = r_c_hour;
    assign o_minute = r_c_minute;
    assign o_second = r_c_second;
    assign o_tag    = r_c_tag;

endmodule

// ===== rtl/time_of_day_arithmetic_unit.sv =====
// Time-of-day arithmetic unit, top level.
// Depends on tod_pkg, tod_amod and tod_split.
//
// Takes one transaction every clock: busy is low at all times except in
// reset and until r_rdy sets after it. Each transaction gives exactly one
// result, in order, on the o_ ports with o_done high for one cycle. The
// path from the start port to the result registers has six register ranks:
// input, amount folding, modulo-675 step with day wrap setup, hour select,
// minute split and result. There is no way to hold results off; the
// receiver must take each one as it comes.
module time_of_day_arithmetic_unit import tod_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [4:0]  i_first_hour,
    input  logic [5:0]  i_first_minute,
    input  logic [5:0]  i_first_second,
    input  logic [4:0]  i_second_hour,
    input  logic [5:0]  i_second_minute,
    input  logic [5:0]  i_second_second,
    input  logic [30:0] i_amount,
    output logic        o_done,
    output logic [4:0]  o_out_hour,
    output logic [5:0]  o_out_minute,
    output logic [5:0]  o_out_second,
    output logic [16:0] o_out_seconds,
    output logic        o_is_valid,
    output logic        o_is_equal,
    output logic        o_is_less,
    output logic        o_is_greater
);

    logic        r_rdy;
    logic        w_take;

    logic        r1_vld;
    t_op         r1_op;
    logic [4:0]  r1_fh;
    logic [5:0]  r1_fm;
    logic [5:0]  r1_fs;
    logic [4:0]  r1_sh;
    logic [5:0]  r1_sm;
    logic [5:0]  r1_ss;
    logic [30:0] r1_amount;

    t_secs       w_t1;
    t_secs       w_t2;
    t_secs       w_dur;
    logic [17:0] w_wrap_dur;
    t_secs       n_t1m;
    t_tag        n_tag;

    logic        r2_vld;
    t_op         r2_op;
    t_tag        r2_tag;
    t_secs       r2_t1m;

    logic        r3_vld;
    t_op         r3_op;
    t_tag        r3_tag;
    t_secs       r3_t1m;

    t_secs       w_amod;
    logic [17:0] n_sum;
    t_secs       n_secs;

    logic        w_vld;
    t_tag        w_tag;

    assign busy   = ~r_rdy;
    assign w_take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy  <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r_rdy  <= 1'b1;
            r1_vld <= w_take;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op     <= i_req_type;
        r1_fh     <= i_first_hour;
        r1_fm     <= i_first_minute;
        r1_fs     <= i_first_second;
        r1_sh     <= i_second_hour;
        r1_sm     <= i_second_minute;
        r1_ss     <= i_second_second;
        r1_amount <= i_amount;
    end

    assign w_t1 = 17'(r1_fh) * 17'(C_HOUR) + 17'(r1_fm) * 17'(C_MIN) + 17'(r1_fs);
    assign w_t2 = 17'(r1_sh) * 17'(C_HOUR) + 17'(r1_sm) * 17'(C_MIN) + 17'(r1_ss);
    assign w_wrap_dur = 18'(w_t2) + 18'(C_DAY) - 18'(w_t1);

    always_comb begin
        if (w_t2 < w_t1) begin
            w_dur = w_wrap_dur[16:0];
        end else begin
            w_dur = w_t2 - w_t1;
        end
        if (w_t1 >= 17'(C_DAY)) begin
            n_t1m = w_t1 - 17'(C_DAY);
        end else begin
            n_t1m = w_t1;
        end
    end

    always_comb begin
        n_tag            = '0;
        n_tag.is_valid   = (r1_fh <= 5'(C_MAX_HOUR)) && (r1_fm <= 6'(C_MAX_MS))
                           && (r1_fs <= 6'(C_MAX_MS));
        case (r1_op)
            OP_VALIDATE: n_tag.seconds = '0;
            OP_TO_SECS:  n_tag.seconds = w_t1;
            OP_COMPARE: begin
                n_tag.is_equal   = (w_t1 == w_t2);
                n_tag.is_less    = (w_t1 < w_t2);
                n_tag.is_greater = (w_t1 > w_t2);
            end
            OP_DURATION: n_tag.seconds = w_dur;
            default: n_tag.seconds = '0;
        endcase
    end

    tod_amod u_amod (
        .i_clk    (i_clk),
        .i_amount (r1_amount),
        .o_rem    (w_amod)
    );

    always_ff @(posedge i_clk) begin
        r2_op  <= r1_op;
        r2_tag <= n_tag;
        r2_t1m <= n_t1m;
        r3_op  <= r2_op;
        r3_tag <= r2_tag;
        r3_t1m <= r2_t1m;
    end

    always_comb begin
        case (r3_op)
            OP_TO_TIME: n_sum = 18'(w_amod);
            OP_ADD:     n_sum = 18'(r3_t1m) + 18'(w_amod);
            OP_SUB:     n_sum = 18'(r3_t1m) + (18'(C_DAY) - 18'(w_amod));
            default:    n_sum = '0;
        endcase
        if (n_sum >= 18'(C_DAY)) begin
            n_secs = 17'(n_sum - 18'(C_DAY));
        end else begin
            n_secs = n_sum[16:0];
        end
    end

    tod_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r3_vld),
        .i_secs   (n_secs),
        .i_tag    (r3_tag),
        .o_vld    (w_vld),
        .o_hour   (o_out_hour),
        .o_minute (o_out_minute),
        .o_second (o_out_second),
        .o_tag    (w_tag)
    );

    assign o_done        = w_vld;
    assign o_out_seconds = w_tag.seconds;
    assign o_is_valid    = w_tag.is_valid;
    assign o_is_equal    = w_tag.is_equal;
    assign o_is_less     = w_tag.is_less;
    assign o_is_greater  = w_tag.is_greater;

    a_done_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##6 o_done)
        else $error("transaction taken without a result six edges later");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_take, 6))
        else $error("result strobe without a matching transaction");

    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out_hour <= 5'(C_MAX_HOUR)) && (o_out_minute <= 6'(C_MAX_MS))
                   && (o_out_second <= 6'(C_MAX_MS)))
        else $error("split time out of range");

    a_compare_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_is_equal, o_is_less, o_is_greater}))
        else $error("compare flags not exclusive");

    a_compare_no_seconds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_is_equal || o_is_less || o_is_greater)
        |-> (o_out_seconds == 17'd0) && (o_out_hour == 5'd0))
        else $error("compare result carries seconds or time");

endmodule

// ===== bench/tb_time_of_day_arithmetic_unit.sv =====
// Self-checking testbench for the time-of-day arithmetic unit.
// Depends on tod_pkg and time_of_day_arithmetic_unit; predicts every result
// in order from the request ports and compares each strobed result field by field.
module tb_time_of_day_arithmetic_unit;
    import tod_pkg::*;

    localparam int RUN_LIMIT   = 100000;
    localparam int RANDOM_REQS = 900;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        t_op         op;
        logic [4:0]  first_hour;
        logic [5:0]  first_minute;
        logic [5:0]  first_second;
        logic [4:0]  second_hour;
        logic [5:0]  second_minute;
        logic [5:0]  second_second;
        logic [30:0] amount;
        int          idle_pct;
    } t_tod_request;

    typedef struct {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [16:0] seconds;
        logic        valid;
        logic        equal;
        logic        less;
        logic        greater;
    } t_tod_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = OP_VALIDATE;
    logic [4:0]  i_first_hour = '0;
    logic [5:0]  i_first_minute = '0;
    logic [5:0]  i_first_second = '0;
    logic [4:0]  i_second_hour = '0;
    logic [5:0]  i_second_minute = '0;
    logic [5:0]  i_second_second = '0;
    logic [30:0] i_amount = '0;
    logic        o_done;
    logic [4:0]  o_out_hour;
    logic [5:0]  o_out_minute;
    logic [5:0]  o_out_second;
    logic [16:0] o_out_seconds;
    logic        o_is_valid;
    logic        o_is_equal;
    logic        o_is_less;
    logic        o_is_greater;

    t_tod_request pending_requests[$];
    t_tod_result  expected_results[$];
    t_tod_request next_request;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    time_of_day_arithmetic_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_first_hour    (i_first_hour),
        .i_first_minute  (i_first_minute),
        .i_first_second  (i_first_second),
        .i_second_hour   (i_second_hour),
        .i_second_minute (i_second_minute),
        .i_second_second (i_second_second),
        .i_amount        (i_amount),
        .o_done          (o_done),
        .o_out_hour      (o_out_hour),
        .o_out_minute    (o_out_minute),
        .o_out_second    (o_out_second),
        .o_out_seconds   (o_out_seconds),
        .o_is_valid      (o_is_valid),
        .o_is_equal      (o_is_equal),
        .o_is_less       (o_is_less),
        .o_is_greater    (o_is_greater)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic t_tod_result split_day_seconds(longint unsigned secs);
        t_tod_result     res;
        longint unsigned rem;
        res = '{default: '0};
        rem = secs % C_DAY;
        res.hour   = 5'(rem / C_HOUR);
        rem        = rem % C_HOUR;
        res.minute = 6'(rem / C_MIN);
        res.second = 6'(rem % C_MIN);
        return res;
    endfunction

    function automatic t_tod_result predict_time_result(
        t_op op, logic [4:0] fh, logic [5:0] fm, logic [5:0] fs,
        logic [4:0] sh, logic [5:0] sm, logic [5:0] ss, logic [30:0] amt);
        t_tod_result     res;
        longint unsigned first_secs;
        longint unsigned second_secs;
        longint unsigned amount_secs;
        logic            valid;
        first_secs  = C_HOUR * longint'(fh) + C_MIN * longint'(fm) + longint'(fs);
        second_secs = C_HOUR * longint'(sh) + C_MIN * longint'(sm) + longint'(ss);
        amount_secs = longint'(amt);
        valid = (fh <= C_MAX_HOUR) && (fm <= C_MAX_MS) && (fs <= C_MAX_MS);
        res = '{default: '0};
        case (op)
            OP_TO_SECS: begin
                res.seconds = 17'(first_secs);
            end
            OP_TO_TIME: begin
                res = split_day_seconds(amount_secs);
            end
            OP_COMPARE: begin
                res.equal   = first_secs == second_secs;
                res.less    = first_secs < second_secs;
                res.greater = first_secs > second_secs;
            end
            OP_ADD: begin
                res = split_day_seconds(first_secs + amount_secs);
            end
            OP_SUB: begin
                res = split_day_seconds((first_secs % C_DAY) + C_DAY - (amount_secs % C_DAY));
            end
            OP_DURATION: begin
                if (second_secs < first_secs) begin
                    res.seconds = 17'(second_secs + C_DAY - first_secs);
                end else begin
                    res.seconds = 17'(second_secs - first_secs);
                end
            end
            default: begin
            end
        endcase
        res.valid = valid;
        return res;
    endfunction

    task automatic check_field(string name, longint unsigned exp_val, longint unsigned act_val);
        if (exp_val != act_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endtask

    task automatic queue_request(t_op op, logic [4:0] fh, logic [5:0] fm, logic [5:0] fs,
                                 logic [4:0] sh, logic [5:0] sm, logic [5:0] ss,
                                 logic [30:0] amt, int idle_pct);
        t_tod_request req;
        req.op            = op;
        req.first_hour    = fh;
        req.first_minute  = fm;
        req.first_second  = fs;
        req.second_hour   = sh;
        req.second_minute = sm;
        req.second_second = ss;
        req.amount        = amt;
        req.idle_pct      = idle_pct;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_request(int idle_pct);
        t_op             op;
        logic [4:0]      fh;
        logic [5:0]      fm;
        logic [5:0]      fs;
        longint unsigned amt;
        op = t_op'($urandom_range(int'(OP_DURATION), int'(OP_VALIDATE)));
        if ($urandom_range(99) < 75) begin
            fh = 5'($urandom_range(C_MAX_HOUR));
            fm = 6'($urandom_range(C_MAX_MS));
            fs = 6'($urandom_range(C_MAX_MS));
        end else begin
            fh = 5'($urandom);
            fm = 6'($urandom);
            fs = 6'($urandom);
        end
        case ($urandom_range(3))
            0: amt = $urandom_range(2 * C_DAY);
            1: amt = longint'($urandom_range(24000)) * C_DAY + $urandom_range(2) - 1;
            2: amt = $urandom;
            default: amt = 64'h7FFF_FFFF - $urandom_range(C_DAY);
        endcase
        queue_request(op, fh, fm, fs, 5'($urandom_range(C_MAX_HOUR)),
                      6'($urandom_range(C_MAX_MS)), 6'($urandom_range(C_MAX_MS)),
                      31'(amt), idle_pct);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (pending_requests.size() != 0
                && $urandom_range(99) >= pending_requests[0].idle_pct) begin
                next_request = pending_requests.pop_front();
                start           <= 1'b1;
                i_req_type      <= next_request.op;
                i_first_hour    <= next_request.first_hour;
                i_first_minute  <= next_request.first_minute;
                i_first_second  <= next_request.first_second;
                i_second_hour   <= next_request.second_hour;
                i_second_minute <= next_request.second_minute;
                i_second_second <= next_request.second_second;
                i_amount        <= next_request.amount;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tod_result exp_res;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, actual hms %0d:%0d:%0d secs %0d",
                             $time, o_out_hour, o_out_minute, o_out_second, o_out_seconds);
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("out_hour", exp_res.hour, o_out_hour);
                    check_field("out_minute", exp_res.minute, o_out_minute);
                    check_field("out_second", exp_res.second, o_out_second);
                    check_field("out_seconds", exp_res.seconds, o_out_seconds);
                    check_field("is_valid", exp_res.valid, o_is_valid);
                    check_field("is_equal", exp_res.equal, o_is_equal);
                    check_field("is_less", exp_res.less, o_is_less);
                    check_field("is_greater", exp_res.greater, o_is_greater);
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_time_result(i_req_type, i_first_hour,
                    i_first_minute, i_first_second, i_second_hour, i_second_minute,
                    i_second_second, i_amount));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        queue_request(OP_VALIDATE, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_VALIDATE, 5'd23, 6'd59, 6'd59, 5'd23, 6'd59, 6'd59, 31'd0, 0);
        queue_request(OP_VALIDATE, 5'd24, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_VALIDATE, 5'd0, 6'd60, 6'd0, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_VALIDATE, 5'd0, 6'd0, 6'd60, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_TO_SECS, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_TO_SECS, 5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 31'h7FFF_FFFF, 0);
        queue_request(OP_TO_TIME, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_TO_TIME, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd86399, 0);
        queue_request(OP_TO_TIME, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd86400, 0);
        queue_request(OP_TO_TIME, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'h7FFF_FFFF, 0);
        queue_request(OP_COMPARE, 5'd12, 6'd30, 6'd30, 5'd12, 6'd30, 6'd30, 31'd0, 0);
        queue_request(OP_COMPARE, 5'd0, 6'd0, 6'd0, 5'd23, 6'd59, 6'd59, 31'd0, 0);
        queue_request(OP_COMPARE, 5'd31, 6'd63, 6'd63, 5'd23, 6'd59, 6'd59, 31'd0, 0);
        queue_request(OP_ADD, 5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 31'd1, 0);
        queue_request(OP_ADD, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 31'h7FFF_FFFF, 0);
        queue_request(OP_ADD, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_SUB, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd1, 0);
        queue_request(OP_SUB, 5'd12, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_SUB, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 31'h7FFF_FFFF, 0);
        queue_request(OP_SUB, 5'd5, 6'd6, 6'd7, 5'd0, 6'd0, 6'd0, 31'd86400, 0);
        queue_request(OP_DURATION, 5'd8, 6'd0, 6'd0, 5'd8, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_DURATION, 5'd1, 6'd2, 6'd3, 5'd22, 6'd33, 6'd44, 31'd0, 0);
        queue_request(OP_DURATION, 5'd23, 6'd0, 6'd0, 5'd1, 6'd0, 6'd0, 31'd0, 0);
        queue_request(OP_DURATION, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 31'd0, 0);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n < RANDOM_REQS / 3) begin
                queue_random_request(28);
            end else if (n < 2 * RANDOM_REQS / 3) begin
                queue_random_request(58);
            end else begin
                queue_random_request(0);
            end
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_requests.size() != 0 || start || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
